// ----- hw/rtl/srie_pkg.sv -----
// shared types and constants for the six-register instruction executor
// no dependencies; used by srie_alu and the top level

package srie_pkg;

  // register file geometry
  parameter int NUM_REGS = 6;
  parameter int IDX_W = 3;
  parameter logic [IDX_W-1:0] REG_LAST = IDX_W'(NUM_REGS - 1);

  // default data word width
  parameter int DEFAULT_WORD_WIDTH = 32;

  // instruction opcodes
  typedef enum logic [3:0] {
    OP_INC      = 4'd0,
    OP_DEC      = 4'd1,
    OP_SHOWDEC  = 4'd2,
    OP_SHOWCHAR = 4'd3,
    OP_NEWLINE  = 4'd4,
    OP_COPY     = 4'd5,
    OP_CLEAR    = 4'd6,
    OP_READ     = 4'd7,
    OP_ADD      = 4'd8,
    OP_SUB      = 4'd9,
    OP_MUL      = 4'd10,
    OP_SHL      = 4'd11,
    OP_SHR      = 4'd12,
    OP_IFEQ     = 4'd13,
    OP_NOP      = 4'd14,
    OP_INVALID  = 4'd15
  } op_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DEC  = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_NL   = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  // control from the execute logic to the top level
  typedef struct packed {
    logic  wr_en;
    logic  res_vld;
    kind_t res_kind;
    logic  halt_set;
    logic  cnt_inc;
  } ctl_t;

endpackage

// ----- hw/rtl/srie_alu.sv -----
// execute logic: decodes one instruction and computes write-back data and result
// depends on srie_pkg

module srie_alu #(
  parameter int WORD_WIDTH = srie_pkg::DEFAULT_WORD_WIDTH
) (
  input  logic [3:0]                  op,
  input  logic [srie_pkg::IDX_W-1:0]  dest,
  input  logic [srie_pkg::IDX_W-1:0]  src,
  input  logic [8:0]                  read_byte,
  input  logic [WORD_WIDTH-1:0]       dv,
  input  logic [WORD_WIDTH-1:0]       sv,
  input  logic                        halted,
  input  logic [31:0]                 cnt,
  output srie_pkg::ctl_t              ctl,
  output logic [WORD_WIDTH-1:0]       wr_data,
  output logic [31:0]                 res_value
);

  localparam int SHW = $clog2(WORD_WIDTH);
  localparam logic [WORD_WIDTH-1:0] SH_LIMIT = WORD_WIDTH'(WORD_WIDTH);

  srie_pkg::op_t           opc;
  logic                    needs_d;
  logic                    needs_s;
  logic                    idx_bad;
  logic                    amt_ovf;
  logic [WORD_WIDTH-1:0]   shl_w;
  logic [WORD_WIDTH-1:0]   shr_w;
  logic [WORD_WIDTH-1:0]   mul_w;
  logic [WORD_WIDTH+31:0]  dv_ext;
  logic [WORD_WIDTH+8:0]   rb_ext;

  assign opc = srie_pkg::op_t'(op);

  // which register indexes the opcode really uses
  assign needs_d = !(opc == srie_pkg::OP_NEWLINE || opc == srie_pkg::OP_NOP);
  assign needs_s = (opc == srie_pkg::OP_COPY) || (opc == srie_pkg::OP_ADD) ||
                   (opc == srie_pkg::OP_SUB) || (opc == srie_pkg::OP_MUL) ||
                   (opc == srie_pkg::OP_SHL) || (opc == srie_pkg::OP_SHR) ||
                   (opc == srie_pkg::OP_IFEQ);
  assign idx_bad = (needs_d && (dest > srie_pkg::REG_LAST)) ||
                   (needs_s && (src > srie_pkg::REG_LAST));

  // shifts: negative or too large amount saturates
  assign amt_ovf = sv[WORD_WIDTH-1] || (sv >= SH_LIMIT);
  assign shl_w = amt_ovf ? '0 : (dv << sv[SHW-1:0]);
  assign shr_w = amt_ovf ? {WORD_WIDTH{dv[WORD_WIDTH-1]}}
                         : WORD_WIDTH'($signed(dv) >>> sv[SHW-1:0]);

  // wrapping product, low word only
  assign mul_w = dv * sv;

  // zero-extended view for decimal show, sign-extended input byte
  assign dv_ext = {32'd0, dv};
  assign rb_ext = {{WORD_WIDTH{read_byte[8]}}, read_byte};

  // instruction decode and result selection
  always_comb begin
    ctl       = '0;
    ctl.res_kind = srie_pkg::KIND_DEC;
    wr_data   = dv;
    res_value = '0;
    if (!halted) begin
      if (opc == srie_pkg::OP_INVALID) begin
        ctl.res_vld  = 1'b1;
        ctl.res_kind = srie_pkg::KIND_ERR;
        ctl.halt_set = 1'b1;
        res_value    = cnt + 32'd1;
      end else begin
        ctl.cnt_inc = 1'b1;
        if (!idx_bad) begin
          case (opc)
            srie_pkg::OP_INC: begin
              ctl.wr_en = 1'b1;
              wr_data   = dv + WORD_WIDTH'(1);
            end
            srie_pkg::OP_DEC: begin
              ctl.wr_en = 1'b1;
              wr_data   = dv - WORD_WIDTH'(1);
            end
            srie_pkg::OP_SHOWDEC: begin
              ctl.res_vld  = 1'b1;
              ctl.res_kind = srie_pkg::KIND_DEC;
              res_value    = dv_ext[31:0];
            end
            srie_pkg::OP_SHOWCHAR: begin
              ctl.res_vld  = 1'b1;
              ctl.res_kind = srie_pkg::KIND_CHAR;
              res_value    = {24'd0, dv[7:0]};
            end
            srie_pkg::OP_NEWLINE: begin
              ctl.res_vld  = 1'b1;
              ctl.res_kind = srie_pkg::KIND_NL;
            end
            srie_pkg::OP_COPY: begin
              ctl.wr_en = 1'b1;
              wr_data   = sv;
            end
            srie_pkg::OP_CLEAR: begin
              ctl.wr_en = 1'b1;
              wr_data   = '0;
            end
            srie_pkg::OP_READ: begin
              ctl.wr_en = 1'b1;
              wr_data   = rb_ext[WORD_WIDTH-1:0];
            end
            srie_pkg::OP_ADD: begin
              ctl.wr_en = 1'b1;
              wr_data   = dv + sv;
            end
            srie_pkg::OP_SUB: begin
              ctl.wr_en = 1'b1;
              wr_data   = dv - sv;
            end
            srie_pkg::OP_MUL: begin
              ctl.wr_en = 1'b1;
              wr_data   = mul_w;
            end
            srie_pkg::OP_SHL: begin
              ctl.wr_en = 1'b1;
              wr_data   = shl_w;
            end
            srie_pkg::OP_SHR: begin
              ctl.wr_en = 1'b1;
              wr_data   = shr_w;
            end
            srie_pkg::OP_IFEQ: begin
              if (dv == sv) begin
                ctl.res_vld  = 1'b1;
                ctl.res_kind = srie_pkg::KIND_CHAR;
                res_value    = {24'd0, dv[7:0]};
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

endmodule

// ----- hw/rtl/six_register_instruction_executor_top.sv -----
// top level of the six-register instruction executor
// depends on srie_pkg and srie_alu

// Takes one decoded instruction per clock unless the input is stalled, and runs
// it on six signed registers of WORD_WIDTH bits. An instruction is captured in
// the input register together with its two operands, read from the register file
// at that edge (with bypass of the write-back that happens at the same edge);
// from the input register it executes and writes back, and any result goes into
// the output register. Throughput is one instruction per cycle while no result
// is blocked, set by the single execute stage. The output register holds a
// stalled result while the next instruction waits in the input register, and
// only an instruction that produces a result is held back by a stalled output.
// An invalid opcode gives an error result carrying the 1-based instruction number
// and halts the block until reset; later instructions are taken and dropped.

module six_register_instruction_executor_top #(
  parameter int WORD_WIDTH = srie_pkg::DEFAULT_WORD_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [3:0]                  in_op,
  input  logic [2:0]                  in_dest,
  input  logic [2:0]                  in_src,
  input  logic signed [8:0]           in_read_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_kind,
  output logic signed [31:0]          out_value
);

  // register file storage and per-entry valid bits
  logic [WORD_WIDTH-1:0]              mem [srie_pkg::NUM_REGS];
  logic [srie_pkg::NUM_REGS-1:0]      rf_vld_r;

  // input stage
  logic                               s1_vld_r;
  logic [3:0]                         op_r;
  logic [srie_pkg::IDX_W-1:0]         dest_r;
  logic [srie_pkg::IDX_W-1:0]         src_r;
  logic [8:0]                         rb_r;
  logic [WORD_WIDTH-1:0]              dv_r;
  logic [WORD_WIDTH-1:0]              sv_r;

  // architectural state
  logic [31:0]                        cnt_r;
  logic                               halted_r;

  // output stage
  logic                               out_vld_r;
  srie_pkg::kind_t                    out_kind_r;
  logic [31:0]                        out_value_r;

  logic                               s1_vld_nxt;
  logic                               out_vld_nxt;
  logic                               advance;
  logic                               in_acc;
  logic                               wr_en;
  srie_pkg::ctl_t                     ctl;
  logic [WORD_WIDTH-1:0]              wr_data;
  logic [31:0]                        res_value;

  // execute logic
  srie_alu #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_alu (
    .op        (op_r),
    .dest      (dest_r),
    .src       (src_r),
    .read_byte (rb_r),
    .dv        (dv_r),
    .sv        (sv_r),
    .halted    (halted_r),
    .cnt       (cnt_r),
    .ctl       (ctl),
    .wr_data   (wr_data),
    .res_value (res_value)
  );

  // handshake: the executing instruction moves on unless its result is blocked
  assign advance  = s1_vld_r && (!ctl.res_vld || !out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !advance;
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = advance && ctl.wr_en;

  assign s1_vld_nxt  = in_acc ? 1'b1 : (advance ? 1'b0 : s1_vld_r);
  assign out_vld_nxt = (advance && ctl.res_vld) ? 1'b1 : (out_stall && out_vld_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cnt_r     <= '0;
      halted_r  <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance && ctl.cnt_inc) begin
        cnt_r <= cnt_r + 32'd1;
      end
      if (advance && ctl.halt_set) begin
        halted_r <= 1'b1;
      end
    end
  end

  // register file valid bits: an entry reads as zero until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (wr_en) begin
      rf_vld_r[dest_r] <= 1'b1;
    end
  end

  // register file write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[dest_r] <= wr_data;
    end
  end

  // input capture with operand read and write-back bypass
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      dest_r <= in_dest;
      src_r  <= in_src;
      rb_r   <= in_read_byte;
      if (wr_en && (dest_r == in_dest)) begin
        dv_r <= wr_data;
      end else if ((in_dest <= srie_pkg::REG_LAST) && rf_vld_r[in_dest]) begin
        dv_r <= mem[in_dest];
      end else begin
        dv_r <= '0;
      end
      if (wr_en && (dest_r == in_src)) begin
        sv_r <= wr_data;
      end else if ((in_src <= srie_pkg::REG_LAST) && rf_vld_r[in_src]) begin
        sv_r <= mem[in_src];
      end else begin
        sv_r <= '0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance && ctl.res_vld) begin
      out_kind_r  <= ctl.res_kind;
      out_value_r <= res_value;
    end
  end

  assign out_valid = out_vld_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;

`ifndef SYNTHESIS
  // once halted, only reset leaves the halted state
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halted state cleared without reset");

  // a halted block never writes the register file
  a_no_write_halted: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !wr_en)
    else $error("register write while halted");

  // a pending error result implies the block is halted
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_kind_r == srie_pkg::KIND_ERR)) |-> halted_r)
    else $error("error result without halt");

  // input is held back only by a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_vld_r && out_vld_r && out_stall && ctl.res_vld))
    else $error("input stalled without a blocked result");

  // instruction count moves only when an instruction executes
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(cnt_r))
    else $error("instruction count changed without execution");
`endif

endmodule
